// ----- sv/tclc_pkg.sv -----
// ----------------------------------------------------------------------------
// tclc_pkg: shared types and constants for the text cell layout block
// Command/status types between controller and datapath, draw kinds,
// configuration register indexes and character codes.
// ----------------------------------------------------------------------------
package tclc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] CFG_NARROW_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_NARROW_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_WIDE_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_WIDE_HEIGHT   = 3'd5;
    localparam logic [2:0] CFG_ENTRY_COUNT   = 3'd6;

    // draw kinds
    localparam logic [1:0] KIND_ASCII = 2'd0;
    localparam logic [1:0] KIND_WIDE  = 2'd1;
    localparam logic [1:0] KIND_BOX   = 2'd2;

    // character codes
    localparam logic [7:0] CHR_NUL      = 8'h00;
    localparam logic [7:0] CHR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHR_FIRST    = 8'd32;
    localparam logic [7:0] CHR_LAST     = 8'd126;
    localparam logic [7:0] CHR_LEAD_MIN = 8'h80;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_END,
        OP_NEWLINE,
        OP_HOLD,
        OP_ASCII,
        OP_CTRL,
        OP_SEARCH,
        OP_STEP,
        OP_WIDE
    } t_op;

    // class of the captured text byte
    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_NEWLINE,
        CLS_LEAD,
        CLS_PRINT,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        logic accept;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic req;
        logic ended;
        logic lead;
        t_cls cls;
        logic out_free;
        logic srch_done;
    } t_sts;

endpackage

// ----- sv/tclc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tclc_ctrl: sequencing controller
// Takes one transaction at a time, picks the datapath operation for it,
// runs the code table search and waits for the result register.
// ----------------------------------------------------------------------------
module tclc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  tclc_pkg::t_sts   i_sts,
    output tclc_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_WIDE
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, n_stall;
    logic   accept;

    assign accept = i_in_valid && !r_stall;

    always_comb begin
        n_state      = r_state;
        n_stall      = r_stall;
        o_cmd.accept = accept;
        o_cmd.op     = tclc_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                    n_stall = 1'b1;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_stall = 1'b0;
                if (i_sts.req || i_sts.ended) begin
                    o_cmd.op = tclc_pkg::OP_NONE;
                end else if (i_sts.lead) begin
                    if (i_sts.cls == tclc_pkg::CLS_ZERO) begin
                        o_cmd.op = tclc_pkg::OP_END;
                    end else begin
                        o_cmd.op = tclc_pkg::OP_SEARCH;
                        n_state  = S_SEARCH;
                        n_stall  = 1'b1;
                    end
                end else begin
                    case (i_sts.cls)
                        tclc_pkg::CLS_ZERO:    o_cmd.op = tclc_pkg::OP_END;
                        tclc_pkg::CLS_NEWLINE: o_cmd.op = tclc_pkg::OP_NEWLINE;
                        tclc_pkg::CLS_LEAD:    o_cmd.op = tclc_pkg::OP_HOLD;
                        tclc_pkg::CLS_PRINT: begin
                            if (i_sts.out_free) begin
                                o_cmd.op = tclc_pkg::OP_ASCII;
                            end else begin
                                n_state = S_EXEC;
                                n_stall = 1'b1;
                            end
                        end
                        default:               o_cmd.op = tclc_pkg::OP_CTRL;
                    endcase
                end
            end
            S_SEARCH: begin
                o_cmd.op = tclc_pkg::OP_STEP;
                if (i_sts.srch_done) begin
                    n_state = S_WIDE;
                end
            end
            S_WIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = tclc_pkg::OP_WIDE;
                    n_state  = S_IDLE;
                    n_stall  = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_in_stall = r_stall;

endmodule

// ----- sv/tclc_dp.sv -----
// ----------------------------------------------------------------------------
// tclc_dp: layout datapath
// Configuration registers, cursor and lead-byte state, code table memory
// with its one-slot-per-cycle search, and the result register.
// ----------------------------------------------------------------------------
module tclc_dp #(
    parameter int TABLE_DEPTH  = 64,
    parameter int SCREEN_WIDTH = 240
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tclc_pkg::t_cmd   i_cmd,
    output tclc_pkg::t_sts   o_sts,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_addr,
    input  logic [15:0]      i_cfg_wdata,
    input  logic             i_req_type,
    input  logic             i_string_start,
    input  logic [7:0]       i_text_byte,
    input  logic [5:0]       i_entry_slot,
    input  logic [15:0]      i_entry_code,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [1:0]       o_draw_kind,
    output logic [15:0]      o_pos_x,
    output logic [15:0]      o_pos_y,
    output logic [7:0]       o_cell_width,
    output logic [7:0]       o_cell_height,
    output logic [6:0]       o_glyph_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic [15:0] r_origin_x, r_origin_y;
    logic [7:0]  r_narrow_w, r_narrow_h, r_wide_w, r_wide_h;
    logic [6:0]  r_entry_count;

    // cursor and string state
    logic [15:0] r_col, n_col, r_row, n_row;
    logic [7:0]  r_held, n_held;
    logic        r_lead, n_lead, r_ended, n_ended;

    // captured transaction
    logic        r_req;
    logic [7:0]  r_byte;

    // code table and search
    logic [15:0]   mem [TABLE_DEPTH];
    logic [15:0]   r_rd_data;
    logic [CW-1:0] r_addr, r_chk_idx, r_found, lim;
    logic          r_chk_vld, r_hit;
    logic          rd_en, match, load_we;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_pos_x, r_pos_y;
    logic [7:0]  r_cw, n_cw, r_ch, n_ch;
    logic [6:0]  r_idx, n_idx;
    logic        out_load, out_free;

    logic [7:0]  adv_w;
    logic [15:0] col_adv, col_chk;
    logic        wrap;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= 16'd0;
            r_origin_y    <= 16'd0;
            r_narrow_w    <= 8'd8;
            r_narrow_h    <= 8'd16;
            r_wide_w      <= 8'd16;
            r_wide_h      <= 8'd16;
            r_entry_count <= 7'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tclc_pkg::CFG_ORIGIN_X:      r_origin_x    <= i_cfg_wdata;
                tclc_pkg::CFG_ORIGIN_Y:      r_origin_y    <= i_cfg_wdata;
                tclc_pkg::CFG_NARROW_WIDTH:  r_narrow_w    <= i_cfg_wdata[7:0];
                tclc_pkg::CFG_NARROW_HEIGHT: r_narrow_h    <= i_cfg_wdata[7:0];
                tclc_pkg::CFG_WIDE_WIDTH:    r_wide_w      <= i_cfg_wdata[7:0];
                tclc_pkg::CFG_WIDE_HEIGHT:   r_wide_h      <= i_cfg_wdata[7:0];
                tclc_pkg::CFG_ENTRY_COUNT:   r_entry_count <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // ---------------- status ----------------
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.req       = r_req;
        o_sts.ended     = r_ended;
        o_sts.lead      = r_lead;
        o_sts.out_free  = out_free;
        o_sts.srch_done = match || (!r_chk_vld && !(r_addr < lim));
        if (r_byte == tclc_pkg::CHR_NUL) begin
            o_sts.cls = tclc_pkg::CLS_ZERO;
        end else if (r_byte == tclc_pkg::CHR_NEWLINE) begin
            o_sts.cls = tclc_pkg::CLS_NEWLINE;
        end else if (r_byte >= tclc_pkg::CHR_LEAD_MIN) begin
            o_sts.cls = tclc_pkg::CLS_LEAD;
        end else if (r_byte >= tclc_pkg::CHR_FIRST && r_byte <= tclc_pkg::CHR_LAST) begin
            o_sts.cls = tclc_pkg::CLS_PRINT;
        end else begin
            o_sts.cls = tclc_pkg::CLS_OTHER;
        end
    end

    // ---------------- cursor update ----------------
    assign adv_w   = (i_cmd.op == tclc_pkg::OP_WIDE) ? r_wide_w : r_narrow_w;
    assign col_adv = r_col + {8'd0, adv_w};
    assign col_chk = (i_cmd.op == tclc_pkg::OP_CTRL) ? r_col : col_adv;
    // look-ahead is done at 17 bits, no 16-bit wrap
    assign wrap    = ({1'b0, col_chk} + {9'd0, r_narrow_w}) > 17'(SCREEN_WIDTH);

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_held   = r_held;
        n_lead   = r_lead;
        n_ended  = r_ended;
        out_load = 1'b0;
        n_kind   = tclc_pkg::KIND_ASCII;
        n_cw     = r_narrow_w;
        n_ch     = r_narrow_h;
        n_idx    = 7'(r_byte - tclc_pkg::CHR_FIRST);
        if (i_cmd.accept && i_string_start) begin
            n_col   = r_origin_x;
            n_row   = r_origin_y;
            n_held  = 8'd0;
            n_lead  = 1'b0;
            n_ended = 1'b0;
        end
        case (i_cmd.op)
            tclc_pkg::OP_END: begin
                n_ended = 1'b1;
                n_lead  = 1'b0;
                n_held  = 8'd0;
            end
            tclc_pkg::OP_NEWLINE: begin
                n_col = r_origin_x;
                n_row = r_row + {8'd0, r_narrow_h};
            end
            tclc_pkg::OP_HOLD: begin
                n_held = r_byte;
                n_lead = 1'b1;
            end
            tclc_pkg::OP_SEARCH: begin
                n_lead = 1'b0;
            end
            tclc_pkg::OP_ASCII, tclc_pkg::OP_WIDE: begin
                out_load = 1'b1;
                n_col    = col_adv;
                if (wrap) begin
                    n_col = r_origin_x;
                    n_row = r_row + {8'd0, r_wide_h};
                end
                if (i_cmd.op == tclc_pkg::OP_WIDE) begin
                    n_kind = r_hit ? tclc_pkg::KIND_WIDE : tclc_pkg::KIND_BOX;
                    n_cw   = r_wide_w;
                    n_ch   = r_wide_h;
                    n_idx  = r_hit ? 7'(r_found) : 7'd0;
                end
            end
            tclc_pkg::OP_CTRL: begin
                if (wrap) begin
                    n_col = r_origin_x;
                    n_row = r_row + {8'd0, r_wide_h};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= 16'd0;
            r_row       <= 16'd0;
            r_held      <= 8'd0;
            r_lead      <= 1'b0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_held  <= n_held;
            r_lead  <= n_lead;
            r_ended <= n_ended;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_req_type;
            r_byte <= i_text_byte;
        end
        if (out_load) begin
            r_kind  <= n_kind;
            r_pos_x <= r_col;
            r_pos_y <= r_row;
            r_cw    <= n_cw;
            r_ch    <= n_ch;
            r_idx   <= n_idx;
        end
    end

    // ---------------- code table search ----------------
    assign lim     = (int'(r_entry_count) >= TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                          : CW'(r_entry_count);
    assign rd_en   = (i_cmd.op == tclc_pkg::OP_STEP) && (r_addr < lim);
    assign match   = r_chk_vld && ((r_rd_data == {r_held, r_byte}) ||
                                   (r_rd_data == {r_byte, r_held}));
    assign load_we = i_cmd.accept && i_req_type && (int'(i_entry_slot) < TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else if (i_cmd.op == tclc_pkg::OP_SEARCH) begin
            r_chk_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else if (i_cmd.op == tclc_pkg::OP_STEP) begin
            r_chk_vld <= rd_en;
            if (match) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tclc_pkg::OP_SEARCH) begin
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr    <= r_addr + CW'(1);
            r_chk_idx <= r_addr;
        end
        if (i_cmd.op == tclc_pkg::OP_STEP && match) begin
            r_found <= r_chk_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem[AW'(i_entry_slot)] <= i_entry_code;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_addr[AW-1:0]];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_draw_kind   = r_kind;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_cell_width  = r_cw;
    assign o_cell_height = r_ch;
    assign o_glyph_index = r_idx;

endmodule

// ----- sv/text_cell_layout_with_code_lookup_top.sv -----
// ----------------------------------------------------------------------------
// text_cell_layout_with_code_lookup_top: character cell text layout
// Turns a text byte stream into glyph draw commands (cell position, size,
// glyph index), with newline, wrap and a double-byte code table lookup.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall   | req_type, string_start,
//          |           |                           | text_byte, entry_slot,
//          |           |                           | entry_code
//  out     | output    | o_out_valid / i_out_stall | draw_kind, pos_x, pos_y,
//          |           |                           | cell_width, cell_height,
//          |           |                           | glyph_index
//  cfg     | input     | i_cfg_we (write only)     | i_cfg_addr, i_cfg_wdata
//
//  One transaction at a time: a table load or a single text byte is
//  captured, then executed. The byte that completes a double-byte pair
//  runs the code table search, one slot per cycle through the memory read
//  port, until a hit or until the configured entry count is exhausted.
//  Stall on the result side holds a pending result in the execute stage;
//  the result register lets the next transaction in while one waits.
//  Reset is synchronous, active low; the code table is not cleared.
// ----------------------------------------------------------------------------
module text_cell_layout_with_code_lookup_top #(
    parameter int TABLE_DEPTH  = 64,
    parameter int SCREEN_WIDTH = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic        i_string_start,
    input  logic [7:0]  i_text_byte,
    input  logic [5:0]  i_entry_slot,
    input  logic [15:0] i_entry_code,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_draw_kind,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [7:0]  o_cell_width,
    output logic [7:0]  o_cell_height,
    output logic [6:0]  o_glyph_index
);

    // controller picks one datapath operation per cycle; datapath reports
    // byte class, string flags, search completion and result slot status
    tclc_pkg::t_cmd cmd;
    tclc_pkg::t_sts sts;

    tclc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tclc_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_req_type),
        .i_string_start (i_string_start),
        .i_text_byte    (i_text_byte),
        .i_entry_slot   (i_entry_slot),
        .i_entry_code   (i_entry_code),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_draw_kind    (o_draw_kind),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_cell_width   (o_cell_width),
        .o_cell_height  (o_cell_height),
        .o_glyph_index  (o_glyph_index)
    );

    // ---------------- assertions ----------------
    // an accepted transaction always blocks the input for its execute cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // a new result is only produced while a transaction is in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no transaction in flight");

    // missing box always points at glyph 0
    a_box_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_draw_kind == tclc_pkg::KIND_BOX) |-> (o_glyph_index == 7'd0))
        else $error("missing box with nonzero glyph index");

    // draw kind stays within the defined codes
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_draw_kind == tclc_pkg::KIND_ASCII ||
                         o_draw_kind == tclc_pkg::KIND_WIDE ||
                         o_draw_kind == tclc_pkg::KIND_BOX))
        else $error("undefined draw kind");

endmodule
